// ===== src/round_robin_task_scheduler_with_waits_defines.svh =====
// Assertion macros for the round robin task scheduler.
// No dependencies; included by the top level.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_WITH_WAITS_DEFINES_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_WITH_WAITS_DEFINES_SVH

// implication checked at every edge outside reset
`define RRTS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrts assertion failed");

// implication checked in the cycle after the antecedent
`define RRTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrts assertion failed");

`endif

// ===== src/rrts_pkg.sv =====
// Shared types and codes for the round robin task scheduler.
// No dependencies.
package rrts_pkg;

    localparam int MAX_TASKS_DEF = 8;
    localparam int IDX_MAX_W = 5;
    localparam int CNT_MAX_W = 6;

    localparam logic [1:0] ST_READY   = 2'd0;
    localparam logic [1:0] ST_RUNNING = 2'd1;
    localparam logic [1:0] ST_BLOCKED = 2'd2;
    localparam logic [1:0] ST_RETIRED = 2'd3;

    localparam logic [2:0] MODE_SPAWN = 3'd0;
    localparam logic [2:0] MODE_START = 3'd1;
    localparam logic [2:0] MODE_TICK  = 3'd2;
    localparam logic [2:0] MODE_BLOCK = 3'd3;
    localparam logic [2:0] MODE_WAKE  = 3'd4;
    localparam logic [2:0] MODE_YIELD = 3'd5;
    localparam logic [2:0] MODE_EXIT  = 3'd6;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_SPAWN,
        OP_SETST,
        OP_BLOCK,
        OP_EXPIRE,
        OP_DLK,
        OP_WAKE
    } cell_op_t;

    typedef struct packed {
        cell_op_t               op;
        logic [IDX_MAX_W-1:0]   idx;
        logic [1:0]             st;
        logic [31:0]            addr;
        logic [31:0]            dl;
        logic                   rty;
        logic [31:0]            now;
        logic [CNT_MAX_W-1:0]   count;
        logic [3:0]             lim;
    } cell_cmd_t;

    typedef struct packed {
        logic                   valid;
        logic [CNT_MAX_W-1:0]   cnt;
    } wake_tok_t;

endpackage

// ===== src/rrts_cell.sv =====
// One task slot: status, wait address, deadline and retry flag.
// Uses rrts_pkg; passes the wake token to its neighbour.
module rrts_cell #(
    parameter int ME = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rrts_pkg::cell_cmd_t   cmd,
    input  rrts_pkg::wake_tok_t   tok_in,
    output rrts_pkg::wake_tok_t   tok_out,
    output logic [1:0]            status,
    output logic                  rel,
    output logic                  wr
);
    import rrts_pkg::*;

    logic [1:0]  status_reg, status_next;
    logic        retry_reg, retry_next;
    logic [31:0] addr_reg;
    logic [31:0] dl_reg;
    wake_tok_t   tok_reg;
    logic        mine, inr, blk;
    logic [31:0] diff;

    assign mine = cmd.idx == IDX_MAX_W'(ME);
    assign inr  = CNT_MAX_W'(ME) < cmd.count;
    assign blk  = status_reg == ST_BLOCKED;
    assign diff = cmd.now - dl_reg;

    always_comb
    begin
        case (cmd.op)
            OP_EXPIRE: rel = inr && blk && (dl_reg != 32'd0) && !diff[31];
            OP_DLK:    rel = inr && blk;
            OP_WAKE:   rel = tok_in.valid && inr && blk && (addr_reg == cmd.addr)
                             && (tok_in.cnt < {2'b00, cmd.lim});
            default:   rel = 1'b0;
        endcase
    end

    assign wr = rel && !retry_reg;

    always_comb
    begin
        status_next = status_reg;
        retry_next  = retry_reg;
        if (rel)
        begin
            status_next = ST_READY;
            retry_next  = 1'b0;
        end
        else if (mine)
        begin
            case (cmd.op)
                OP_SPAWN:
                begin
                    status_next = ST_READY;
                    retry_next  = 1'b0;
                end
                OP_SETST: status_next = cmd.st;
                OP_BLOCK:
                begin
                    status_next = ST_BLOCKED;
                    retry_next  = cmd.rty;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg    <= ST_READY;
            retry_reg     <= 1'b0;
            tok_reg.valid <= 1'b0;
            tok_reg.cnt   <= '0;
        end
        else
        begin
            status_reg    <= status_next;
            retry_reg     <= retry_next;
            tok_reg.valid <= tok_in.valid && (cmd.op == OP_WAKE);
            tok_reg.cnt   <= tok_in.cnt + CNT_MAX_W'(rel);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mine && cmd.op == OP_BLOCK)
        begin
            addr_reg <= cmd.addr;
            dl_reg   <= cmd.dl;
        end
    end

    assign tok_out = tok_reg;
    assign status  = status_reg;

endmodule

// ===== src/round_robin_task_scheduler_with_waits.sv =====
// Round robin task scheduler with address and timed waits: top level.
// Uses rrts_pkg, rrts_cell and the defines header.
//
// Input channel (in_valid/in_stall) takes one operation beat: mode plus its
// operands. Output channel (out_valid/out_stall) returns one result beat per
// operation. in_stall is high while an operation is in progress; a finished
// result sits in the output register, and a new operation may be taken
// while it waits to be collected.
// Spawn, ignored operations and wakes to address 0 go from the execute state
// straight to the done state; start passes through the run state and a
// non-preempting tick through the preempt check. Block, yield, exit and
// preempting ticks scan the slot row one slot a cycle.
// A wake walks a token along the row of cells.
// One operation at a time; the next is taken the cycle after a result loads.
// slice_reg is written over the APB port at address 0.
// Reset (rst_n low, asynchronous) empties the table, stops scheduling and
// drops any pending result. A stalled result holds until taken.
module round_robin_task_scheduler_with_waits #(
    parameter int MAX_TASKS = rrts_pkg::MAX_TASKS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         mode,
    input  logic               user_mode,
    input  logic [31:0]        now,
    input  logic [31:0]        wait_address,
    input  logic [31:0]        deadline,
    input  logic               retry,
    input  logic [3:0]         wake_limit,
    input  logic signed [31:0] wake_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               accepted,
    output logic [2:0]         new_slot,
    output logic [2:0]         running_slot,
    output logic               running_valid,
    output logic               switched,
    output logic               finished,
    output logic [7:0]         timeout_mask,
    output logic [7:0]         deadlock_mask,
    output logic [7:0]         signal_mask,
    output logic [7:0]         value_write_mask,
    output logic signed [31:0] signal_value,
    output logic [3:0]         woken_count
);
    import rrts_pkg::*;
    `include "round_robin_task_scheduler_with_waits_defines.svh"

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EXEC = 4'd1;
    localparam logic [3:0] S_PRE  = 4'd2;
    localparam logic [3:0] S_FIND = 4'd3;
    localparam logic [3:0] S_DLK  = 4'd4;
    localparam logic [3:0] S_POST = 4'd5;
    localparam logic [3:0] S_RUN  = 4'd6;
    localparam logic [3:0] S_WAKE = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]  state_reg, state_next;
    logic [7:0]  slice_reg;
    logic [7:0]  cd_reg, cd_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic        present_reg, present_next;
    logic        running_reg, running_next;

    logic [2:0]  mode_reg;
    logic        user_reg;
    logic [31:0] now_reg, addr_reg, dl_reg, wval_reg;
    logic        rty_reg;
    logic [3:0]  lim_reg;

    logic        acc_reg, acc_next, sw_reg, sw_next, fin_reg, fin_next;
    logic [IW-1:0] nslot_reg, nslot_next;
    logic [7:0]  tm_reg, tm_next, dm_reg, dm_next, sm_reg, sm_next, wm_reg, wm_next;
    logic [3:0]  woken_reg, woken_next;

    logic [IW-1:0] idx_reg, idx_next, base_next, fidx_reg, fidx_next, nidx;
    logic [CW-1:0] steps_reg, steps_next;
    logic        found_reg, found_next, second_reg, second_next;
    logic [CW-1:0] wstep_reg, wstep_next;

    logic        ov_reg;
    logic        o_acc_reg, o_rv_reg, o_sw_reg, o_fin_reg;
    logic [2:0]  o_ns_reg, o_rs_reg;
    logic [7:0]  o_tm_reg, o_dm_reg, o_sm_reg, o_wm_reg;
    logic [31:0] o_sv_reg;
    logic [3:0]  o_wc_reg;

    cell_cmd_t   cmd;
    wake_tok_t   tok [MAX_TASKS+1];
    logic [2*MAX_TASKS-1:0] st_flat;
    logic [MAX_TASKS-1:0]   rel_v, wr_v, run_v;
    logic [MAX_TASKS+7:0]   rel_pad, wr_pad;
    logic [7:0]  rel8, wr8;
    logic        live, take_in, take_out;
    logic [IW+2:0] ns_pad, rs_pad;

    genvar g;
    generate
        for (g = 0; g < MAX_TASKS; g++)
        begin : g_cell
            rrts_cell #(.ME(g)) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .cmd     (cmd),
                .tok_in  (tok[g]),
                .tok_out (tok[g+1]),
                .status  (st_flat[2*g+1:2*g]),
                .rel     (rel_v[g]),
                .wr      (wr_v[g])
            );
            assign run_v[g] = !st_flat[2*g+1];
        end
    endgenerate

    assign rel_pad = {8'd0, rel_v};
    assign wr_pad  = {8'd0, wr_v};
    assign rel8    = rel_pad[7:0];
    assign wr8     = wr_pad[7:0];

    assign tok[0].valid = (state_reg == S_EXEC) && (mode_reg == MODE_WAKE)
                          && (addr_reg != 32'd0);
    assign tok[0].cnt   = '0;

    // APB
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {24'd0, slice_reg};
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slice_reg <= 8'd2;
        else if (psel && penable && pwrite && !paddr[2])
            slice_reg <= pwdata[7:0];
    end

    assign live     = running_reg && present_reg;
    assign in_stall = state_reg != S_IDLE;
    assign take_in  = in_valid && !in_stall;
    assign take_out = !ov_reg || !out_stall;
    assign nidx     = (CW'(idx_reg) + CW'(1) == count_reg) ? '0 : IW'(idx_reg + IW'(1));
    assign base_next = (present_reg && CW'(cur_reg) < count_reg) ? cur_reg : '0;

    always_comb
    begin
        state_next   = state_reg;
        cd_next      = cd_reg;
        count_next   = count_reg;
        cur_next     = cur_reg;
        present_next = present_reg;
        running_next = running_reg;
        acc_next = acc_reg; sw_next = sw_reg; fin_next = fin_reg;
        nslot_next = nslot_reg;
        tm_next = tm_reg; dm_next = dm_reg; sm_next = sm_reg;
        wm_next = wm_reg | wr8;
        woken_next = woken_reg;
        idx_next = idx_reg; steps_next = steps_reg; fidx_next = fidx_reg;
        found_next = found_reg; second_next = second_reg;
        wstep_next = wstep_reg;

        cmd       = '0;
        cmd.op    = OP_NOP;
        cmd.idx   = IDX_MAX_W'(cur_reg);
        cmd.addr  = addr_reg;
        cmd.dl    = dl_reg;
        cmd.rty   = rty_reg;
        cmd.now   = now_reg;
        cmd.count = CNT_MAX_W'(count_reg);
        cmd.lim   = lim_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (take_in)
                begin
                    state_next = S_EXEC;
                    acc_next = 1'b0; sw_next = 1'b0; fin_next = 1'b0;
                    nslot_next = '0; woken_next = 4'd0;
                    tm_next = '0; dm_next = '0; sm_next = '0; wm_next = '0;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                case (mode_reg)
                    MODE_SPAWN:
                        if (count_reg < CW'(MAX_TASKS))
                        begin
                            cmd.op     = OP_SPAWN;
                            cmd.idx    = IDX_MAX_W'(count_reg);
                            count_next = count_reg + CW'(1);
                            acc_next   = 1'b1;
                            nslot_next = IW'(count_reg);
                        end
                    MODE_START:
                        if (!running_reg && count_reg != '0 && st_flat[1:0] == ST_READY)
                        begin
                            running_next = 1'b1;
                            cd_next      = slice_reg;
                            fidx_next    = '0;
                            state_next   = S_RUN;
                        end
                    MODE_TICK:
                        if (live)
                        begin
                            cmd.op     = OP_EXPIRE;
                            tm_next    = rel8;
                            state_next = S_PRE;
                        end
                    MODE_BLOCK, MODE_YIELD:
                        if (live)
                        begin
                            idx_next = base_next; steps_next = '0; second_next = 1'b0;
                            state_next = S_FIND;
                        end
                    MODE_WAKE:
                        if (addr_reg != 32'd0)
                        begin
                            cmd.op     = OP_WAKE;
                            sm_next    = rel8;
                            wstep_next = CW'(1);
                            state_next = S_WAKE;
                        end
                    MODE_EXIT:
                        if (present_reg)
                        begin
                            cmd.op = OP_SETST;
                            cmd.st = ST_RETIRED;
                            idx_next = base_next; steps_next = '0; second_next = 1'b0;
                            state_next = S_FIND;
                        end
                    default: ;
                endcase
            end
            S_PRE:
            begin
                state_next = S_DONE;
                if (user_reg)
                begin
                    if (cd_reg != 8'd0)
                        cd_next = cd_reg - 8'd1;
                    else
                    begin
                        cd_next = slice_reg;
                        cmd.op  = OP_SETST;
                        cmd.st  = ST_READY;
                        idx_next = base_next; steps_next = '0; second_next = 1'b0;
                        state_next = S_FIND;
                    end
                end
            end
            S_FIND:
            begin
                if (run_v[nidx])
                begin
                    found_next = 1'b1;
                    fidx_next  = nidx;
                    state_next = S_POST;
                end
                else
                begin
                    idx_next   = nidx;
                    steps_next = steps_reg + CW'(1);
                    if (steps_reg + CW'(1) >= count_reg)
                    begin
                        found_next = 1'b0;
                        state_next = second_reg ? S_POST : S_DLK;
                    end
                end
            end
            S_DLK:
            begin
                cmd.op  = OP_DLK;
                dm_next = dm_reg | rel8;
                if (|rel_v)
                begin
                    idx_next = base_next; steps_next = '0; second_next = 1'b1;
                    state_next = S_FIND;
                end
                else
                begin
                    found_next = 1'b0;
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                state_next = S_DONE;
                case (mode_reg)
                    MODE_TICK:
                        if (found_reg)
                            state_next = S_RUN;
                        else
                        begin
                            cmd.op = OP_SETST;
                            cmd.st = ST_RUNNING;
                        end
                    MODE_EXIT:
                        if (found_reg)
                            state_next = S_RUN;
                        else
                        begin
                            running_next = 1'b0;
                            present_next = 1'b0;
                            cur_next     = '0;
                            fin_next     = 1'b1;
                            sw_next      = 1'b1;
                        end
                    default:
                        if (found_reg && fidx_reg != cur_reg)
                        begin
                            if (mode_reg == MODE_BLOCK)
                                cmd.op = OP_BLOCK;
                            else
                            begin
                                cmd.op = OP_SETST;
                                cmd.st = ST_READY;
                            end
                            cd_next    = slice_reg;
                            acc_next   = 1'b1;
                            state_next = S_RUN;
                        end
                endcase
            end
            S_RUN:
            begin
                cmd.op       = OP_SETST;
                cmd.idx      = IDX_MAX_W'(fidx_reg);
                cmd.st       = ST_RUNNING;
                sw_next      = !present_reg || cur_reg != fidx_reg;
                cur_next     = fidx_reg;
                present_next = 1'b1;
                state_next   = S_DONE;
            end
            S_WAKE:
            begin
                cmd.op     = OP_WAKE;
                sm_next    = sm_reg | rel8;
                wstep_next = wstep_reg + CW'(1);
                if (wstep_reg == CW'(MAX_TASKS))
                begin
                    woken_next = tok[MAX_TASKS].cnt[3:0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
                if (take_out)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cd_reg      <= 8'd2;
            count_reg   <= '0;
            cur_reg     <= '0;
            present_reg <= 1'b0;
            running_reg <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cd_reg      <= cd_next;
            count_reg   <= count_next;
            cur_reg     <= cur_next;
            present_reg <= present_next;
            running_reg <= running_next;
            if (state_reg == S_DONE && take_out)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    assign ns_pad = {3'd0, nslot_reg};
    assign rs_pad = {3'd0, cur_reg};

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            mode_reg <= mode;
            user_reg <= user_mode;
            now_reg  <= now;
            addr_reg <= wait_address;
            dl_reg   <= deadline;
            rty_reg  <= retry;
            lim_reg  <= wake_limit;
            wval_reg <= wake_value;
        end
        acc_reg <= acc_next; sw_reg <= sw_next; fin_reg <= fin_next;
        nslot_reg <= nslot_next; woken_reg <= woken_next;
        tm_reg <= tm_next; dm_reg <= dm_next; sm_reg <= sm_next; wm_reg <= wm_next;
        idx_reg <= idx_next; steps_reg <= steps_next; fidx_reg <= fidx_next;
        found_reg <= found_next; second_reg <= second_next; wstep_reg <= wstep_next;
        if (state_reg == S_DONE && take_out)
        begin
            o_acc_reg <= acc_reg;
            o_ns_reg  <= ns_pad[2:0];
            o_rs_reg  <= present_reg ? rs_pad[2:0] : 3'd0;
            o_rv_reg  <= present_reg;
            o_sw_reg  <= sw_reg;
            o_fin_reg <= fin_reg;
            o_tm_reg  <= tm_reg;
            o_dm_reg  <= dm_reg;
            o_sm_reg  <= sm_reg;
            o_wm_reg  <= wm_reg;
            o_sv_reg  <= (mode_reg == MODE_WAKE) ? wval_reg : 32'd0;
            o_wc_reg  <= woken_reg;
        end
    end

    assign out_valid        = ov_reg;
    assign accepted         = o_acc_reg;
    assign new_slot         = o_ns_reg;
    assign running_slot     = o_rs_reg;
    assign running_valid    = o_rv_reg;
    assign switched         = o_sw_reg;
    assign finished         = o_fin_reg;
    assign timeout_mask     = o_tm_reg;
    assign deadlock_mask    = o_dm_reg;
    assign signal_mask      = o_sm_reg;
    assign value_write_mask = o_wm_reg;
    assign signal_value     = o_sv_reg;
    assign woken_count      = o_wc_reg;

    `RRTS_ASSERT_IMP(a_busy_stalls, state_reg != S_IDLE, in_stall)
    `RRTS_ASSERT_IMP(a_fin_stops, out_valid && finished, switched && !running_valid)
    `RRTS_ASSERT_NEXT(a_accept_exec, take_in, state_reg == S_EXEC)

endmodule
